>>> design/duplicate_packet_filter_crc32_core_macros.svh
// Assertion helpers used by the top-level design file.
`ifndef DUPLICATE_PACKET_FILTER_CRC32_CORE_MACROS_SVH
`define DUPLICATE_PACKET_FILTER_CRC32_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DPF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DPF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dpf_pkg.sv
package dpf_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

    // Finished packet CRC handed from the CRC unit to the history
    typedef struct packed {
        logic        done;
        logic [31:0] crc;
    } t_crc_res;

    // One result beat
    typedef struct packed {
        logic        is_new;
        logic [31:0] crc;
    } t_result;

    // Reflected CRC-32 update over one byte, LSB first
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'h0, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> design/dpf_crc.sv
module dpf_crc
    import dpf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic [7:0] i_data,
    input  logic     i_last,
    output t_crc_res o_res
);

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] w_upd;

    assign w_upd = crc32_byte(r_crc, i_data);

    always_comb begin
        n_crc = r_crc;
        if (i_accept) begin
            // restart for the next packet after the last beat
            n_crc = i_last ? CRC_ALL_ONES : w_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_ALL_ONES;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_res.done = i_accept & i_last;
    assign o_res.crc  = ~w_upd;

endmodule

>>> design/dpf_hist.sv
module dpf_hist
    import dpf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_crc_res i_res,
    output t_result  o_result
);

    logic [31:0]           r_entry [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] r_valid;
    logic [HIST_IDX_W-1:0] r_slot;
    logic [HIST_IDX_W-1:0] n_slot;
    logic [HISTORY_DEPTH-1:0] w_hit;
    logic                  w_new;

    // compare against every live entry at once
    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            w_hit[i] = r_valid[i] & (r_entry[i] == i_res.crc);
        end
    end

    assign w_new = ~(|w_hit);

    always_comb begin
        n_slot = r_slot;
        if (i_res.done && w_new) begin
            if (r_slot == HIST_IDX_W'(HISTORY_DEPTH - 1)) begin
                n_slot = '0;
            end else begin
                n_slot = r_slot + HIST_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_slot  <= '0;
        end else begin
            r_slot <= n_slot;
            if (i_res.done && w_new) begin
                r_valid[r_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.done && w_new) begin
            r_entry[r_slot] <= i_res.crc;
        end
    end

    assign o_result.is_new = w_new;
    assign o_result.crc    = i_res.crc;

endmodule

>>> design/dpf_skid.sv
module dpf_skid
    import dpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_load;

    assign w_load  = !r_out_valid || i_ready;
    assign o_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            // hold the beat until the output register frees up
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> design/duplicate_packet_filter_crc32_core.sv
// Duplicate packet filter keyed on CRC-32 (reflected, init and final XOR all ones).
// Input stream: one payload byte per beat in i_s_tdata, i_s_tlast on the final
// byte of a packet. Every packet has at least one byte.
// Output stream: one beat per packet, carrying the packet CRC in o_m_tdata and
// the new/duplicate flag in o_m_tuser (1 = CRC not seen among recent packets).
// Throughput: one byte per cycle while o_s_tready is high. The byte CRC update, the
// parallel compare against the 16-entry history and the history write all happen in
// the cycle the final byte is accepted; the result beat is registered and is valid on
// the next cycle when the output register is free, else it waits in the skid stage.
// New CRCs fill the history in order and overwrite the oldest entry once full;
// duplicates leave it untouched.
// Reset sets the running CRC to all ones and clears all history valid marks and the write slot.
// A stalled receiver is absorbed by an output register plus a skid stage:
// bytes keep flowing until two results wait, then o_s_tready drops until
// the receiver takes one.
module duplicate_packet_filter_crc32_core
    import dpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] data_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [31:0] packet_crc
    output logic [0:0]  o_m_tuser     // [0] is_new
);

`include "duplicate_packet_filter_crc32_core_macros.svh"

    logic     w_accept;
    t_crc_res w_crc_res;
    t_result  w_result;
    t_result  w_out;

    assign w_accept = i_s_tvalid & o_s_tready;

    dpf_crc u_crc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_data   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_res    (w_crc_res)
    );

    dpf_hist u_hist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (w_crc_res),
        .o_result (w_result)
    );

    dpf_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_crc_res.done),
        .i_data  (w_result),
        .o_ready (o_s_tready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (w_out)
    );

    assign o_m_tdata    = w_out.crc;
    assign o_m_tuser[0] = w_out.is_new;

    `DPF_ASSERT_NXT(a_result_crc, w_crc_res.done && !o_m_tvalid, o_m_tvalid && (o_m_tdata == $past(w_result.crc)), "result CRC not presented after final byte")
    `DPF_ASSERT_NXT(a_result_flag, w_crc_res.done && !o_m_tvalid, o_m_tuser[0] == $past(w_result.is_new), "result flag not presented after final byte")
    `DPF_ASSERT_IMP(a_stall_cause, !o_s_tready, o_m_tvalid && $past(o_m_tvalid && !i_m_tready), "input stalled without a held result")

endmodule
